// ----- sv/vltp_pkg.sv -----
// Shared constants, types and functions for the vector line transform.
package vltp_pkg;

  localparam int unsigned ANGLE_BITS_DEF  = 12;
  localparam int unsigned SCREEN_BITS_DEF = 12;
  localparam int unsigned OUT_COORD_W     = 12;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MONO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ABERR    = 3'd4;

  localparam logic [15:0] ZOOM_RESET  = 16'd4096;
  localparam logic [7:0]  BLOOM_ALPHA = 8'd100;

  typedef struct packed {
    logic [15:0]        zoom;
    logic signed [15:0] camera_x;
    logic signed [15:0] camera_y;
    logic               mono_enable;
    logic [11:0]        aberration;
  } cfg_t;

  // Polynomial sine in Q16 of the first-quadrant fraction z (0..65536).
  function automatic logic [16:0] sine_poly(input logic [16:0] z);
    logic [33:0] zz;
    logic [16:0] z2;
    logic [33:0] t1;
    logic [16:0] inner;
    logic [33:0] t2;
    logic [16:0] outer;
    logic [34:0] t3;
    logic [18:0] r;
    zz    = 34'(z) * 34'(z);
    z2    = zz[32:16];
    t1    = 34'(z2) * 34'd4640;
    inner = 17'(17'd42048 - 17'(t1[33:16]));
    t2    = 34'(z2) * 34'(inner);
    outer = 17'(17'd102944 - 17'(t2[33:16]));
    t3    = 35'(z) * 35'(outer);
    r     = t3[34:16];
    sine_poly = (r > 19'd65536) ? 17'd65536 : r[16:0];
  endfunction

endpackage

// ----- sv/vltp_trig.sv -----
// Sine and cosine table lookup with registered output.
module vltp_trig #(
  parameter int unsigned ANGLE_BITS = vltp_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [11:0]           heading_i,
  output logic signed [17:0]    sin_o,
  output logic signed [17:0]    cos_o
);
  localparam int unsigned FB = ANGLE_BITS - 2;
  localparam int unsigned ENTRIES = 1 << ANGLE_BITS;

  function automatic logic signed [17:0] sin_of(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]    quad;
    logic [16:0]   z;
    logic [16:0]   s;
    quad = a[ANGLE_BITS-1 -: 2];
    if (FB <= 16) z = 17'(a[FB-1:0]) << (16 - FB);
    else z = 17'(a[FB-1:0] >> (FB - 16));
    if (quad[0]) z = 17'(17'd65536 - z);
    s = vltp_pkg::sine_poly(z);
    sin_of = quad[1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  logic signed [17:0] sin_tab [ENTRIES];
  for (genvar i = 0; i < ENTRIES; i++) begin : g_tab
    assign sin_tab[i] = sin_of(ANGLE_BITS'(i));
  end

  logic [ANGLE_BITS-1:0] ang, angc;
  assign ang  = ANGLE_BITS'(heading_i);
  assign angc = ang + ANGLE_BITS'(1 << FB);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_tab[ang];
      cos_o <= sin_tab[angc];
    end
  end
endmodule

// ----- sv/vltp_xform.sv -----
// Pipelined rotate, scale and offset of both endpoints to Q4 screen space.
module vltp_xform #(
  parameter int unsigned ANGLE_BITS = vltp_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [155:0]       data_i,
  input  vltp_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  output logic signed [33:0] pt_o [4],
  output logic [31:0]        color_o
);
  // stage 1: trig lookup, sz product
  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [15:0] p1_q [4];
  logic signed [15:0] ox1_q, oy1_q;
  logic [31:0]        sz1_q, col1_q;
  logic signed [17:0] s1, c1;

  vltp_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
    .clk_i, .en_i, .heading_i(data_i[107:96]), .sin_o(s1), .cos_o(c1)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) p1_q[i] <= $signed(data_i[16*i +: 16]);
      ox1_q  <= $signed(data_i[79:64]);
      oy1_q  <= $signed(data_i[95:80]);
      sz1_q  <= 32'(data_i[123:108]) * 32'(cfg_i.zoom);
      col1_q <= data_i[155:124];
    end
  end

  // stage 2: products with sine/cosine
  logic signed [33:0] m2_q [8];
  logic signed [15:0] ox2_q, oy2_q;
  logic [31:0]        sz2_q, col2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int e = 0; e < 2; e++) begin
        m2_q[4*e]   <= p1_q[2*e] * c1;
        m2_q[4*e+1] <= p1_q[2*e+1] * s1;
        m2_q[4*e+2] <= p1_q[2*e] * s1;
        m2_q[4*e+3] <= p1_q[2*e+1] * c1;
      end
      ox2_q <= ox1_q; oy2_q <= oy1_q; sz2_q <= sz1_q; col2_q <= col1_q;
    end
  end

  // stage 3: sums, truncating divide by 4096
  logic signed [34:0] r3_d [4];
  logic signed [22:0] r3_q [4];
  logic signed [15:0] ox3_q, oy3_q;
  logic [31:0]        sz3_q, col3_q;
  always_comb begin
    r3_d[0] = 35'(m2_q[0]) - 35'(m2_q[1]);
    r3_d[1] = 35'(m2_q[2]) + 35'(m2_q[3]);
    r3_d[2] = 35'(m2_q[4]) - 35'(m2_q[5]);
    r3_d[3] = 35'(m2_q[6]) + 35'(m2_q[7]);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++)
        r3_q[i] <= 23'((r3_d[i] + (r3_d[i][34] ? 35'sd4095 : 35'sd0)) >>> 12);
      ox3_q <= ox2_q; oy3_q <= oy2_q; sz3_q <= sz2_q; col3_q <= col2_q;
    end
  end

  // stage 4: scale, truncating divide by 2^32, offsets
  logic signed [55:0] sc4 [4];
  logic signed [33:0] q4 [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sc4[i] = 56'(r3_q[i]) * $signed({1'b0, sz3_q});
      q4[i]  = 34'((sc4[i] + (sc4[i][55] ? 56'sh0_FFFF_FFFF : 56'sd0)) >>> 32);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i += 2) begin
        pt_o[i]   <= q4[i] + 34'(ox3_q) - 34'(cfg_i.camera_x);
        pt_o[i+1] <= q4[i+1] + 34'(oy3_q) - 34'(cfg_i.camera_y);
      end
      color_o <= col3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end
  assign valid_o = v4_q;
endmodule

// ----- sv/vltp_emit.sv -----
// Pass sequencer: expands one transformed segment into three line transfers.
module vltp_emit #(
  parameter int unsigned SCREEN_BITS = vltp_pkg::SCREEN_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [33:0] pt_i [4],
  input  logic [31:0]        color_i,
  input  vltp_pkg::cfg_t     cfg_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [79:0]        data_o,
  output logic               last_o
);
  localparam logic signed [34:0] HI = 35'((1 <<< (SCREEN_BITS - 1)) - 1);
  localparam logic signed [34:0] LO = -35'(1 <<< (SCREEN_BITS - 1));

  logic               full_q;
  logic [1:0]         pass_q;
  logic signed [33:0] pt_q [4];
  logic [7:0]         r_q, g_q, b_q, a_q;
  logic               ab_q;
  logic [11:0]        ab_v_q;
  logic               take;
  logic [7:0]         gray;
  logic [31:0]        lum;

  assign lum  = 32'd19595 * 32'(color_i[7:0]) + 32'd38470 * 32'(color_i[15:8])
              + 32'd7471 * 32'(color_i[23:16]);
  assign gray = lum[23:16];

  logic slot_free;
  assign slot_free = !valid_o || ready_i;
  assign ready_o   = !full_q || (pass_q == 2'd2 && slot_free);
  assign take      = valid_i && ready_o;

  function automatic logic [11:0] pix(input logic signed [33:0] v,
                                      input logic signed [12:0] sh,
                                      input logic add);
    logic signed [34:0] s;
    logic signed [34:0] p;
    s = 35'(v) + 35'(sh);
    p = ((s + (s[34] ? 35'sd15 : 35'sd0)) >>> 4) + (add ? 35'sd1 : 35'sd0);
    if (p > HI) p = HI;
    else if (p < LO) p = LO;
    pix = p[11:0];
  endfunction

  logic signed [12:0] shx;
  logic               ax, ay;
  logic [7:0]         ro, go, bo, ao;
  always_comb begin
    shx = 13'sd0; ax = 1'b0; ay = 1'b0;
    ro = r_q; go = g_q; bo = b_q; ao = a_q;
    if (ab_q) begin
      case (pass_q)
        2'd0: begin shx = -$signed({1'b0, ab_v_q}); go = '0; bo = '0; end
        2'd1: begin ro = '0; bo = '0; end
        default: begin shx = $signed({1'b0, ab_v_q}); ro = '0; go = '0; end
      endcase
    end else if (pass_q != 2'd0) begin
      ax = (pass_q == 2'd1); ay = (pass_q == 2'd2);
      ro = r_q >> 1; go = g_q >> 1; bo = b_q >> 1; ao = vltp_pkg::BLOOM_ALPHA;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pt_q   <= pt_i;
      r_q    <= cfg_i.mono_enable ? gray : color_i[7:0];
      g_q    <= cfg_i.mono_enable ? gray : color_i[15:8];
      b_q    <= cfg_i.mono_enable ? gray : color_i[23:16];
      a_q    <= color_i[31:24];
      ab_q   <= cfg_i.aberration != 12'd0;
      ab_v_q <= cfg_i.aberration;
    end
    if (full_q && slot_free) begin
      data_o <= {ao, bo, go, ro, pix(pt_q[3], 13'sd0, ay), pix(pt_q[2], shx, ax),
                 pix(pt_q[1], 13'sd0, ay), pix(pt_q[0], shx, ax)};
      last_o <= pass_q == 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0; pass_q <= 2'd0; valid_o <= 1'b0;
    end else begin
      if (slot_free) valid_o <= full_q;
      if (take) begin
        full_q <= 1'b1; pass_q <= 2'd0;
      end else if (full_q && slot_free) begin
        if (pass_q == 2'd2) full_q <= 1'b0;
        pass_q <= pass_q + 2'd1;
      end
    end
  end

  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> pass_q != 2'd3) else $error("pass index out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(data_o)) else $error("output dropped");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && slot_free && pass_q == 2'd2 && !take |=> !full_q) else $error("pass overrun");
endmodule

// ----- sv/vector_line_transform_passes.sv -----
// Top level: four-stage transform pipeline, then a three-pass line emitter.
// Each segment accepted yields three line transfers on the single output port; the emitter
// takes the next segment only as the last pass of the current one goes out. The transform
// pipeline stalls as a whole when the emitter is still busy.
module vector_line_transform_passes #(
  parameter int unsigned ANGLE_BITS  = vltp_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SCREEN_BITS = vltp_pkg::SCREEN_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vltp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vltp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, end_x, end_y, obj_x, obj_y, heading, size_factor,
  // red_in, green_in, blue_in, alpha_in
  input  logic [159:0]                    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // screen_x0, screen_y0, screen_x1, screen_y1, red_out, green_out, blue_out, alpha_out
  output logic [79:0]                     m_axis_tdata,
  output logic                            m_axis_tlast
);
  vltp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{zoom: vltp_pkg::ZOOM_RESET, camera_x: '0, camera_y: '0,
                 mono_enable: 1'b0, aberration: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vltp_pkg::REG_ZOOM:     cfg_q.zoom        <= cfg_data_i;
        vltp_pkg::REG_CAMERA_X: cfg_q.camera_x    <= $signed(cfg_data_i);
        vltp_pkg::REG_CAMERA_Y: cfg_q.camera_y    <= $signed(cfg_data_i);
        vltp_pkg::REG_MONO:     cfg_q.mono_enable <= cfg_data_i[0];
        vltp_pkg::REG_ABERR:    cfg_q.aberration  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic               x_valid, e_ready, en;
  logic signed [33:0] pt [4];
  logic [31:0]        color;

  assign en            = !x_valid || e_ready;
  assign s_axis_tready = en;

  vltp_xform #(.ANGLE_BITS(ANGLE_BITS)) u_xform (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .data_i(s_axis_tdata[155:0]), .cfg_i(cfg_q),
    .valid_o(x_valid), .pt_o(pt), .color_o(color)
  );

  vltp_emit #(.SCREEN_BITS(SCREEN_BITS)) u_emit (
    .clk_i, .rst_ni, .valid_i(x_valid), .ready_o(e_ready), .pt_i(pt), .color_i(color),
    .cfg_i(cfg_q), .valid_o(m_axis_tvalid), .ready_i(m_axis_tready),
    .data_o(m_axis_tdata), .last_o(m_axis_tlast)
  );
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the vector line transform with stream driver and line monitor.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [vltp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [15:0] size_factor;
    logic [11:0] heading;
    logic signed [15:0] obj_y;
    logic signed [15:0] obj_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_x;
  } segment_t;

  typedef struct packed {
    logic       last;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [11:0] y1;
    logic [11:0] x1;
    logic [11:0] y0;
    logic [11:0] x0;
  } line_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [vltp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [vltp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // start_x, start_y, end_x, end_y, obj_x, obj_y, heading, size_factor,
  // red_in, green_in, blue_in, alpha_in
  logic [159:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // screen_x0, screen_y0, screen_x1, screen_y1, red_out, green_out, blue_out, alpha_out
  logic [79:0] m_axis_tdata;
  logic m_axis_tlast;

  vector_line_transform_passes dut (.*);

  vltp_pkg::cfg_t cur_cfg;
  segment_t seg_queue[$];
  line_t line_queue[$];
  int errors = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_phase = 0;

  initial forever #4 clk_i = ~clk_i;

  function automatic longint sine_q16(int unsigned ang);
    int unsigned quad, q;
    longint unsigned z, z2, r;
    ang &= 12'hFFF;
    quad = ang >> 10;
    q = ang & 10'h3FF;
    z = longint'(q) << 6;
    if (quad & 1) z = 65536 - z;
    z2 = (z * z) >> 16;
    r = (z * (102944 - ((z2 * (42048 - ((z2 * 4640) >> 16))) >> 16))) >> 16;
    if (r > 65536) r = 65536;
    return (quad & 2) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [11:0] to_pixel(longint q4, longint shift, longint add);
    longint p;
    p = (q4 + shift) / 16 + add;
    if (p > 2047) p = 2047;
    if (p < -2048) p = -2048;
    return p[11:0];
  endfunction

  function automatic line_t make_line(longint pt[4], longint shx, longint ax, longint ay,
                                      int r, int g, int b, int a, bit last);
    line_t l;
    l.x0 = to_pixel(pt[0], shx, ax);
    l.y0 = to_pixel(pt[1], 0, ay);
    l.x1 = to_pixel(pt[2], shx, ax);
    l.y1 = to_pixel(pt[3], 0, ay);
    l.red = r[7:0];
    l.green = g[7:0];
    l.blue = b[7:0];
    l.alpha = a[7:0];
    l.last = last;
    return l;
  endfunction

  task automatic predict_lines(segment_t sg);
    longint pt[4], px[2], py[2], s, c, sz, rx, ry, ab;
    int r, g, b, gray;
    s = sine_q16(sg.heading);
    c = sine_q16(sg.heading + 1024);
    sz = longint'(sg.size_factor) * longint'(cur_cfg.zoom);
    px[0] = sg.start_x; py[0] = sg.start_y;
    px[1] = sg.end_x; py[1] = sg.end_y;
    for (int i = 0; i < 2; i++) begin
      rx = (px[i] * c - py[i] * s) / 4096;
      ry = (px[i] * s + py[i] * c) / 4096;
      pt[2*i] = (rx * sz) / 64'sd4294967296 + sg.obj_x - cur_cfg.camera_x;
      pt[2*i+1] = (ry * sz) / 64'sd4294967296 + sg.obj_y - cur_cfg.camera_y;
    end
    r = sg.red; g = sg.green; b = sg.blue;
    if (cur_cfg.mono_enable) begin
      gray = (19595 * r + 38470 * g + 7471 * b) >> 16;
      r = gray; g = gray; b = gray;
    end
    ab = cur_cfg.aberration;
    if (ab > 0) begin
      line_queue.push_back(make_line(pt, -ab, 0, 0, r, 0, 0, sg.alpha, 0));
      line_queue.push_back(make_line(pt, 0, 0, 0, 0, g, 0, sg.alpha, 0));
      line_queue.push_back(make_line(pt, ab, 0, 0, 0, 0, b, sg.alpha, 1));
    end else begin
      line_queue.push_back(make_line(pt, 0, 0, 0, r, g, b, sg.alpha, 0));
      line_queue.push_back(make_line(pt, 0, 1, 0, r/2, g/2, b/2, vltp_pkg::BLOOM_ALPHA, 0));
      line_queue.push_back(make_line(pt, 0, 0, 1, r/2, g/2, b/2, vltp_pkg::BLOOM_ALPHA, 1));
    end
  endtask

  // sender: bursts and gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_lines(segment_t'(s_axis_tdata[155:0]));
      void'(seg_queue.pop_front());
    end
    if (s_axis_tvalid && !s_axis_tready) begin
    end else if (gap_left > 0 || !rst_ni || seg_queue.size() == 0) begin
      s_axis_tvalid <= 1'b0;
      if (gap_left > 0) gap_left <= gap_left - 1;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= 160'(seg_queue[0]);
      if (burst_left == 0) begin
        burst_left <= $urandom_range(12, 0);
        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(5, 1);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[8:7] == 2'b00) m_axis_tready <= 1'b1;
    else if (stall_phase[8:7] == 2'b01) m_axis_tready <= stall_phase[1:0] != 2'b11;
    else m_axis_tready <= $urandom_range(2, 0) != 0;
  end

  always @(posedge clk_i) begin
    line_t got, exp_l;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      if (line_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected line %h", got);
      end else begin
        exp_l = line_queue.pop_front();
        if (got !== exp_l) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h got %h", exp_l, got);
        end
      end
    end
  end

  function automatic segment_t rand_seg(bit wide);
    segment_t sg;
    sg = 156'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (!wide) begin
      sg.size_factor = 16'($urandom_range(8192, 0));
      if ($urandom_range(1, 0)) begin
        sg.start_x = 16'($signed($urandom_range(8191, 0)) - 4096);
        sg.start_y = 16'($signed($urandom_range(8191, 0)) - 4096);
        sg.end_x = 16'($signed($urandom_range(8191, 0)) - 4096);
        sg.end_y = 16'($signed($urandom_range(8191, 0)) - 4096);
        sg.obj_x = 16'($signed($urandom_range(16383, 0)) - 8192);
        sg.obj_y = 16'($signed($urandom_range(16383, 0)) - 8192);
      end
    end
    return sg;
  endfunction

  task automatic drain();
    while (seg_queue.size() != 0 || s_axis_tvalid || line_queue.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vltp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      vltp_pkg::REG_ZOOM: cur_cfg.zoom = val;
      vltp_pkg::REG_CAMERA_X: cur_cfg.camera_x = val;
      vltp_pkg::REG_CAMERA_Y: cur_cfg.camera_y = val;
      vltp_pkg::REG_MONO: cur_cfg.mono_enable = val[0];
      vltp_pkg::REG_ABERR: cur_cfg.aberration = val[11:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    segment_t sg;
    cur_cfg = '{zoom: vltp_pkg::ZOOM_RESET, camera_x: '0, camera_y: '0,
                mono_enable: 1'b0, aberration: '0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, quadrant edges, colors
    for (int i = 0; i < 20; i++) begin
      sg = rand_seg(0);
      sg.heading = 12'(i * 256 + ((i % 3) == 0 ? 0 : i));
      if (i < 4) begin
        sg.start_x = (i & 1) ? 16'sh7FFF : -16'sh8000;
        sg.start_y = (i & 2) ? 16'sh7FFF : -16'sh8000;
        sg.end_x = -sg.start_x - 16'sd1;
        sg.end_y = -sg.start_y - 16'sd1;
        sg.obj_x = (i & 1) ? 16'sh7FFF : -16'sh8000;
        sg.obj_y = (i & 2) ? -16'sh8000 : 16'sh7FFF;
        sg.size_factor = (i < 2) ? 16'hFFFF : 16'h0;
        {sg.red, sg.green, sg.blue, sg.alpha} = (i & 1) ? 32'hFFFFFFFF : 32'h0;
      end
      seg_queue.push_back(sg);
    end
    drain();
    write_reg(vltp_pkg::REG_MONO, 16'd1);
    write_reg(vltp_pkg::REG_ABERR, 16'd4095);
    write_reg(vltp_pkg::REG_ZOOM, 16'hFFFF);
    write_reg(vltp_pkg::REG_CAMERA_X, 16'h8000);
    write_reg(vltp_pkg::REG_CAMERA_Y, 16'h7FFF);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    for (int i = 0; i < 5; i++) seg_queue.push_back(rand_seg(i == 0));
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(vltp_pkg::REG_ZOOM, ph == 0 ? 16'd0 : 16'($urandom_range(8192, 1024)));
      write_reg(vltp_pkg::REG_CAMERA_X, 16'($urandom));
      write_reg(vltp_pkg::REG_CAMERA_Y, 16'($urandom));
      write_reg(vltp_pkg::REG_MONO, 16'(ph & 1));
      write_reg(vltp_pkg::REG_ABERR, (ph % 3 == 0) ? 16'd0 : 16'($urandom_range(4095, 1)));
      for (int i = 0; i < 80; i++) seg_queue.push_back(rand_seg($urandom_range(9, 0) == 0));
      drain();
    end
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
